// ===== src/url_path_trimmer_defines.svh =====
// Assertion macros used by the checker file of the URL path trimmer
// No dependencies; included by files that hold concurrent assertions
`ifndef URL_PATH_TRIMMER_DEFINES_SVH
`define URL_PATH_TRIMMER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define UPT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define UPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/upt_pkg.sv =====
// Package for the URL path trimmer: sizes, character codes, register map
// No dependencies; imported by url_path_trimmer and upt_checker
`default_nettype none

package upt_pkg;

    // longest URL taken into account; the length saturates here
    localparam int MAX_URL_LEN = 4096;
    localparam int LEN_W       = $clog2(MAX_URL_LEN + 1);
    localparam int CHAR_W      = 8;

    // stream data widths, padded to whole bytes
    localparam int IN_DATA_W   = CHAR_W;
    localparam int OUT_FIELD_W = CHAR_W + LEN_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

    // configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_KEEP_QUERY    = 2'd0,
        REG_SEGMENT_LIMIT = 2'd1,
        REG_FOLD_CASE     = 2'd2
    } reg_idx_t;

    // characters of interest
    localparam logic [CHAR_W-1:0] CHAR_QUESTION  = 8'h3F;
    localparam logic [CHAR_W-1:0] CHAR_AMPERSAND = 8'h26;
    localparam logic [CHAR_W-1:0] CHAR_SLASH     = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET    = 8'h20;

endpackage

`default_nettype wire

// ===== src/url_path_trimmer.sv =====
// URL path trimmer: case folding and query / segment cut of a URL byte stream
// Depends on upt_pkg
//
// Usage: the bytes of one URL arrive on the s_ stream, one per transaction,
// with s_tlast on the final byte. Every input transaction gives one output
// transaction on the m_ stream carrying the byte (lower-cased when
// fold_case is set) and, on the transaction with m_tlast, the number of
// bytes of the URL to keep; kept_length reads zero on other transactions.
// The output is valid in the cycle after the input transaction, and one byte
// is taken in every cycle while the receiver does not stall: the per-byte
// scan is a single compare-and-update step between the scan registers and the output register.
// A stalled receiver holds the output register; s_tready stays high while
// the output register is empty or is being emptied in the same cycle.
// Reset clears the configuration registers, the scan state and the output valid.
// Registers on the APB port: keep_query at 0x0, segment_limit at 0x4,
// fold_case at 0x8; write them only while the stream is idle.
`default_nettype none

module url_path_trimmer
    import upt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] char_in
    input  wire logic                  s_tlast,   // last_in
    // output stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // [7:0] char_out, [20:8] kept_length, zero pad
    output logic                       m_tlast,   // last_out
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready
);

    // configuration registers
    logic              keep_query_reg;
    logic [7:0]        segment_limit_reg;
    logic              fold_case_reg;
    reg_idx_t          reg_idx;
    logic              cfg_write;

    // scan state
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [LEN_W-1:0]  q_cut_reg, q_cut_next;
    logic              q_seen_reg, q_seen_next;
    logic [LEN_W-1:0]  a_cut_reg, a_cut_next;
    logic              a_seen_reg, a_seen_next;
    logic [7:0]        slash_cnt_reg, slash_cnt_next;
    logic [LEN_W-1:0]  seg_cut_reg, seg_cut_next;
    logic              seg_done_reg, seg_done_next;

    // state after the current byte, before the end-of-URL clear
    logic [LEN_W-1:0]  idx_upd, q_cut_upd, a_cut_upd, seg_cut_upd;
    logic              q_seen_upd, a_seen_upd, seg_done_upd;
    logic [7:0]        slash_cnt_upd, slash_inc;
    logic [LEN_W-1:0]  pos_inc, kept;
    logic              in_range;

    // output register
    logic              m_valid_reg;
    logic [CHAR_W-1:0] m_char_reg, char_fold;
    logic [LEN_W-1:0]  m_kept_reg;
    logic              m_last_reg;

    logic [CHAR_W-1:0] char_in;
    logic              accept;

    assign char_in  = s_tdata[CHAR_W-1:0];
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // configuration write and read
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_query_reg    <= 1'b0;
            segment_limit_reg <= '0;
            fold_case_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_KEEP_QUERY:    keep_query_reg    <= pwdata[0];
                REG_SEGMENT_LIMIT: segment_limit_reg <= pwdata[7:0];
                REG_FOLD_CASE:     fold_case_reg     <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_KEEP_QUERY:    prdata = {{(DATA_W-1){1'b0}}, keep_query_reg};
            REG_SEGMENT_LIMIT: prdata = {{(DATA_W-8){1'b0}}, segment_limit_reg};
            REG_FOLD_CASE:     prdata = {{(DATA_W-1){1'b0}}, fold_case_reg};
            default:           prdata = '0;
        endcase
    end

    // per-byte scan: first '?', first '&', limiting slash
    assign in_range  = (idx_reg < LEN_W'(MAX_URL_LEN));
    assign pos_inc   = idx_reg + LEN_W'(1);
    assign slash_inc = slash_cnt_reg + 8'd1;

    always_comb
    begin
        idx_upd       = idx_reg;
        q_cut_upd     = q_cut_reg;
        q_seen_upd    = q_seen_reg;
        a_cut_upd     = a_cut_reg;
        a_seen_upd    = a_seen_reg;
        slash_cnt_upd = slash_cnt_reg;
        seg_cut_upd   = seg_cut_reg;
        seg_done_upd  = seg_done_reg;
        if (in_range)
        begin
            if (char_in == CHAR_QUESTION && !q_seen_reg)
            begin
                q_seen_upd = 1'b1;
                q_cut_upd  = idx_reg;
            end
            if (char_in == CHAR_AMPERSAND && !a_seen_reg)
            begin
                a_seen_upd = 1'b1;
                a_cut_upd  = idx_reg;
            end
            // the leading byte never counts as a slash
            if (char_in == CHAR_SLASH && idx_reg != '0 && segment_limit_reg != '0
                && !seg_done_reg)
            begin
                slash_cnt_upd = slash_inc;
                if (slash_inc >= segment_limit_reg)
                begin
                    seg_done_upd = 1'b1;
                    seg_cut_upd  = pos_inc;
                end
            end
            idx_upd = pos_inc;
        end
    end

    // kept length on the final byte: smallest applicable cut
    always_comb
    begin
        kept = idx_upd;
        if (!keep_query_reg)
        begin
            if (q_seen_upd)
            begin
                if (q_cut_upd < kept)
                    kept = q_cut_upd;
            end
            else if (a_seen_upd && a_cut_upd < kept)
            begin
                kept = a_cut_upd;
            end
        end
        if (seg_done_upd && seg_cut_upd < kept)
            kept = seg_cut_upd;
    end

    // next scan state, cleared after the final byte
    always_comb
    begin
        idx_next       = idx_reg;
        q_cut_next     = q_cut_reg;
        q_seen_next    = q_seen_reg;
        a_cut_next     = a_cut_reg;
        a_seen_next    = a_seen_reg;
        slash_cnt_next = slash_cnt_reg;
        seg_cut_next   = seg_cut_reg;
        seg_done_next  = seg_done_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                idx_next       = '0;
                q_cut_next     = '0;
                q_seen_next    = 1'b0;
                a_cut_next     = '0;
                a_seen_next    = 1'b0;
                slash_cnt_next = '0;
                seg_cut_next   = '0;
                seg_done_next  = 1'b0;
            end
            else
            begin
                idx_next       = idx_upd;
                q_cut_next     = q_cut_upd;
                q_seen_next    = q_seen_upd;
                a_cut_next     = a_cut_upd;
                a_seen_next    = a_seen_upd;
                slash_cnt_next = slash_cnt_upd;
                seg_cut_next   = seg_cut_upd;
                seg_done_next  = seg_done_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            q_cut_reg     <= '0;
            q_seen_reg    <= 1'b0;
            a_cut_reg     <= '0;
            a_seen_reg    <= 1'b0;
            slash_cnt_reg <= '0;
            seg_cut_reg   <= '0;
            seg_done_reg  <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            q_cut_reg     <= q_cut_next;
            q_seen_reg    <= q_seen_next;
            a_cut_reg     <= a_cut_next;
            a_seen_reg    <= a_seen_next;
            slash_cnt_reg <= slash_cnt_next;
            seg_cut_reg   <= seg_cut_next;
            seg_done_reg  <= seg_done_next;
        end
    end

    // case folding of upper-case letters
    always_comb
    begin
        char_fold = char_in;
        if (fold_case_reg && char_in inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})
            char_fold = char_in + CASE_OFFSET;
    end

    // output register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (accept)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    // output register: payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_char_reg <= char_fold;
            m_last_reg <= s_tlast;
            m_kept_reg <= s_tlast ? kept : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, m_kept_reg, m_char_reg};

endmodule

`default_nettype wire

// ===== src/upt_checker.sv =====
// Port-level checker for the URL path trimmer, bound to the top level
// Depends on upt_pkg and url_path_trimmer_defines.svh
`include "url_path_trimmer_defines.svh"
`default_nettype none

module upt_checker
    import upt_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic                  m_tlast
);

    logic [LEN_W-1:0] kept_length;

    assign kept_length = m_tdata[CHAR_W +: LEN_W];

    // a stalled result holds
    `UPT_ASSERT_NEXT(a_stall_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    // every input transaction yields a result in the next cycle
    `UPT_ASSERT_NEXT(a_result_follows, clk, rst_n, s_tvalid && s_tready,
        m_tvalid, "no result after input transaction")

    // kept length only on the final byte
    `UPT_ASSERT_IMPLY(a_kept_only_last, clk, rst_n, m_tvalid && !m_tlast,
        kept_length == '0, "kept length set on a non-final byte")

    // kept length never beyond the saturated URL length
    `UPT_ASSERT_IMPLY(a_kept_bound, clk, rst_n, m_tvalid,
        kept_length <= LEN_W'(MAX_URL_LEN), "kept length out of range")

endmodule

bind url_path_trimmer upt_checker u_upt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
